// File: rtl/core/bwg_pkg.sv
// Shared types and constants of the bicubic weight generator.
// Used by bwg_poly and by the top level bicubic_weight_generator_unit; depends on nothing.
package bwg_pkg;

  // Sharpness register and port widths.
  localparam int unsigned A_W     = 16;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned OUT_W   = 16;

  // Internal width of one rounded weight; it holds every weight with room to spare.
  localparam int unsigned WGT_W = 20;

  // Sharpness after reset: A = -1.0 in Q2.14.
  localparam logic signed [A_W-1:0] A_RESET = -16'sd16384;

  // One in the weights' scaling of 16384.
  localparam logic signed [WGT_W-1:0] UNITY = 20'sd16384;

  typedef logic signed [WGT_W-1:0] wgt_t;

  // One set of four tap weights and its valid bit as it moves down the pipeline.
  typedef struct packed {
    logic valid;
    wgt_t far_left;
    wgt_t near_left;
    wgt_t near_right;
    wgt_t far_right;
  } wgt_set_t;

endpackage

// File: rtl/core/bwg_poly.sv
// Three-stage evaluation of the four cubic-convolution polynomials, rounded to Q14.
// Depends on bwg_pkg for the weight types and widths.
module bwg_poly #(
  parameter int unsigned PHASE_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [PHASE_BITS-1:0]            frac_i,
  input  logic signed [bwg_pkg::A_W-1:0]   a_i,
  output bwg_pkg::wgt_set_t                wgt_o
);
  import bwg_pkg::*;

  // E = S - D runs from 1 to S, so it needs one bit more than D.
  localparam int unsigned EW  = PHASE_BITS + 1;
  localparam int unsigned SQW = 2 * PHASE_BITS + 1;
  localparam int unsigned AXW = A_W + EW + 1;
  localparam int unsigned LW  = PHASE_BITS + 20;
  localparam int unsigned NW  = 3 * PHASE_BITS + 22;
  localparam int unsigned SH  = 3 * PHASE_BITS;

  localparam logic [EW-1:0]        SPAN   = EW'(1) << PHASE_BITS;
  localparam logic signed [A_W+1:0] OFF_2 = 18'sd32768;
  localparam logic signed [A_W+1:0] OFF_3 = 18'sd49152;
  localparam logic signed [NW-1:0]  HALF  = NW'(1) << (SH - 1);

  // Stage 1: squares, cross product, linear factors and A times each distance.
  logic                    v1_q;
  logic [SQW-1:0]          sq_d_q, sq_e_q, de_q;
  logic signed [LW-1:0]    lin_d_q, lin_e_q;
  logic signed [AXW-1:0]   ad_q, ae_q;

  logic [EW-1:0]           e_w;
  logic signed [EW:0]      d_s, e_s;
  logic signed [A_W+1:0]   a_ext, a_p2, a_p3;
  logic [SQW-1:0]          sq_d_d, sq_e_d, de_d;
  logic signed [LW-1:0]    lin_d_d, lin_e_d;
  logic signed [AXW-1:0]   ad_d, ae_d;

  always_comb begin
    e_w   = SPAN - EW'(frac_i);
    d_s   = signed'({2'b00, frac_i});
    e_s   = signed'({1'b0, e_w});
    a_ext = (A_W+2)'(a_i);
    a_p2  = a_ext + OFF_2;
    a_p3  = a_ext + OFF_3;
    sq_d_d  = SQW'(frac_i) * SQW'(frac_i);
    sq_e_d  = SQW'(e_w) * SQW'(e_w);
    de_d    = SQW'(frac_i) * SQW'(e_w);
    // (A+2)x - (A+3), with x as a count of 1/S steps.
    lin_d_d = LW'(a_p2) * LW'(d_s) - (LW'(a_p3) <<< PHASE_BITS);
    lin_e_d = LW'(a_p2) * LW'(e_s) - (LW'(a_p3) <<< PHASE_BITS);
    ad_d    = AXW'(a_i) * AXW'(d_s);
    ae_d    = AXW'(a_i) * AXW'(e_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_d_q  <= sq_d_d;
    sq_e_q  <= sq_e_d;
    de_q    <= de_d;
    lin_d_q <= lin_d_d;
    lin_e_q <= lin_e_d;
    ad_q    <= ad_d;
    ae_q    <= ae_d;
  end

  // Stage 2: the four numerators over S^3, one multiplier each.
  logic                  v2_q;
  logic signed [NW-1:0]  n_fl_q, n_nl_q, n_nr_q, n_fr_q;
  logic signed [NW-1:0]  n_fl_d, n_nl_d, n_nr_d, n_fr_d;
  logic signed [SQW:0]   sq_d_s, sq_e_s, de_s;

  always_comb begin
    sq_d_s = signed'({1'b0, sq_d_q});
    sq_e_s = signed'({1'b0, sq_e_q});
    de_s   = signed'({1'b0, de_q});
    n_fl_d = NW'(ae_q) * NW'(de_s);
    n_nl_d = NW'(sq_d_s) * NW'(lin_d_q);
    n_nr_d = NW'(sq_e_s) * NW'(lin_e_q);
    n_fr_d = NW'(ad_q) * NW'(de_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_fl_q <= n_fl_d;
    n_nl_q <= n_nl_d;
    n_nr_q <= n_nr_d;
    n_fr_q <= n_fr_d;
  end

  // Stage 3: add one half and floor by an arithmetic shift; the near taps carry the constant one.
  logic signed [NW-1:0] r_fl, r_nl, r_nr, r_fr;
  wgt_set_t             wgt_d, wgt_q;

  always_comb begin
    r_fl = (n_fl_q + HALF) >>> SH;
    r_nl = (n_nl_q + HALF) >>> SH;
    r_nr = (n_nr_q + HALF) >>> SH;
    r_fr = (n_fr_q + HALF) >>> SH;
    wgt_d.valid      = v2_q;
    wgt_d.far_left   = r_fl[WGT_W-1:0];
    wgt_d.near_left  = r_nl[WGT_W-1:0] + UNITY;
    wgt_d.near_right = r_nr[WGT_W-1:0] + UNITY;
    wgt_d.far_right  = r_fr[WGT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgt_q <= '0;
    end else begin
      wgt_q <= wgt_d;
    end
  end

  assign wgt_o = wgt_q;

endmodule

// File: rtl/core/bicubic_weight_generator_unit.sv
// Top level of the bicubic weight generator: request capture, sharpness register,
// normalisation and result registers. Depends on bwg_pkg and bwg_poly.
//
// The unit turns one sub-pixel phase into the four cubic-convolution tap weights in Q2.14.
// It takes a request on every clock cycle and never raises busy, so start may be held high
// continuously. Each result passes the capture register, the three polynomial stages, the
// normalisation register and the result registers, marked by done_o for exactly one cycle;
// the receiver cannot stall it and must take it then. The rate of one phase per cycle is
// set by the four parallel multipliers of the numerator stage, each of which is used once
// per request. The sharpness register is sampled together with the phase when a request
// is taken, so a write affects only later requests; the register is always ready. Each
// weight is rounded half up from its exact value, then a quarter of the shortfall of their
// sum from one (truncated towards zero) is added to all four, so the weights sum to one
// within three steps of 2^-14. Only the low PHASE_BITS bits of the phase are used.
module bicubic_weight_generator_unit #(
  parameter int unsigned PHASE_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [bwg_pkg::PHASE_W-1:0]            phase_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bwg_pkg::A_W-1:0]                cfg_data_i,
  output logic                                   done_o,
  output logic signed [bwg_pkg::OUT_W-1:0]       weight_far_left_o,
  output logic signed [bwg_pkg::OUT_W-1:0]       weight_near_left_o,
  output logic signed [bwg_pkg::OUT_W-1:0]       weight_near_right_o,
  output logic signed [bwg_pkg::OUT_W-1:0]       weight_far_right_o
);
  import bwg_pkg::*;

  // Phase bits that actually reach the datapath.
  localparam int unsigned TAKE_W = (PHASE_BITS < PHASE_W) ? PHASE_BITS : PHASE_W;

  // The pipeline never holds a request off.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Sharpness register.
  logic signed [A_W-1:0] a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= A_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      a_q <= signed'(cfg_data_i);
    end
  end

  // Request capture: the phase fraction and the sharpness travel together from here on.
  logic                   v0_q;
  logic [PHASE_BITS-1:0]  frac_q;
  logic signed [A_W-1:0]  a_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q   <= PHASE_BITS'(phase_i[TAKE_W-1:0]);
    a_item_q <= a_q;
  end

  wgt_set_t raw;

  bwg_poly #(
    .PHASE_BITS(PHASE_BITS)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .frac_i (frac_q),
    .a_i    (a_item_q),
    .wgt_o  (raw)
  );

  // Normalisation, first half: the correction is a quarter of the shortfall, rounded
  // towards zero, which for a negative shortfall means biasing by three before the shift.
  logic signed [WGT_W+1:0] sum_w, short_w, quart_w;
  wgt_set_t                nrm_q;
  wgt_t                    corr_q, corr_d;

  always_comb begin
    sum_w   = (WGT_W+2)'(raw.far_left) + (WGT_W+2)'(raw.near_left)
            + (WGT_W+2)'(raw.near_right) + (WGT_W+2)'(raw.far_right);
    short_w = (WGT_W+2)'(UNITY) - sum_w;
    if (short_w < 0) begin
      quart_w = (short_w + (WGT_W+2)'(3)) >>> 2;
    end else begin
      quart_w = short_w >>> 2;
    end
    corr_d = quart_w[WGT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '0;
    end else begin
      nrm_q <= raw;
    end
  end

  always_ff @(posedge clk_i) begin
    corr_q <= corr_d;
  end

  // Normalisation, second half: apply the correction and keep the low sixteen bits.
  logic                    done_q;
  logic signed [OUT_W-1:0] fl_q, nl_q, nr_q, fr_q;
  wgt_t                    fl_w, nl_w, nr_w, fr_w;

  always_comb begin
    fl_w = nrm_q.far_left + corr_q;
    nl_w = nrm_q.near_left + corr_q;
    nr_w = nrm_q.near_right + corr_q;
    fr_w = nrm_q.far_right + corr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= nrm_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_q <= fl_w[OUT_W-1:0];
    nl_q <= nl_w[OUT_W-1:0];
    nr_q <= nr_w[OUT_W-1:0];
    fr_q <= fr_w[OUT_W-1:0];
  end

  assign done_o              = done_q;
  assign weight_far_left_o   = fl_q;
  assign weight_near_left_o  = nl_q;
  assign weight_near_right_o = nr_q;
  assign weight_far_right_o  = fr_q;

`ifndef SYNTHESIS
  localparam int unsigned LATENCY = 6;

  logic signed [OUT_W+1:0] out_sum;
  assign out_sum = (OUT_W+2)'(weight_far_left_o) + (OUT_W+2)'(weight_near_left_o)
                 + (OUT_W+2)'(weight_near_right_o) + (OUT_W+2)'(weight_far_right_o);

  // Every result stems from an earlier request.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching request");

  // Every request yields its result.
  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start, LATENCY) && $past(rst_ni, LATENCY) && $past(rst_ni, 1) |-> done_o)
    else $error("request lost in the pipeline");

  // Normalised weights sum to one within three steps.
  a_sum_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_sum >= 18'sd16381) && (out_sum <= 18'sd16387))
    else $error("weights do not sum to one");

  // Phase zero selects the centre tap alone.
  a_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(phase_i[TAKE_W-1:0] == '0, LATENCY) |->
      (weight_far_left_o == 16'sd0) && (weight_near_left_o == 16'sd16384)
      && (weight_near_right_o == 16'sd0) && (weight_far_right_o == 16'sd0))
    else $error("wrong weights at phase zero");
`endif

endmodule

// File: bench/tb.sv
// Self-checking testbench for bicubic_weight_generator_unit: directed and random phases
// under several sharpness settings. Depends on bwg_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
  import bwg_pkg::*;

  localparam int unsigned PHASE_BITS = 8;
  localparam time         CLK_HALF   = 10ns;

  // One set of four tap weights as the result ports carry it.
  typedef struct {
    logic signed [OUT_W-1:0] far_left;
    logic signed [OUT_W-1:0] near_left;
    logic signed [OUT_W-1:0] near_right;
    logic signed [OUT_W-1:0] far_right;
  } tap_weights_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Every input is held at a known value from time zero.
  logic               req_start  = 1'b0;
  logic [PHASE_W-1:0] req_phase  = '0;
  logic               cfg_valid  = 1'b0;
  logic [A_W-1:0]     cfg_data   = '0;

  logic                    dut_busy;
  logic                    cfg_ready;
  logic                    res_done;
  logic signed [OUT_W-1:0] res_far_left;
  logic signed [OUT_W-1:0] res_near_left;
  logic signed [OUT_W-1:0] res_near_right;
  logic signed [OUT_W-1:0] res_far_right;

  // The bench's own copy of the sharpness register, Q2.14.
  logic signed [A_W-1:0] sharpness_q14 = A_RESET;

  // Weights expected for requests that have been taken but not yet answered, oldest first.
  tap_weights_t pending_weights[$];

  int mismatch_count = 0;

  bicubic_weight_generator_unit #(
    .PHASE_BITS(PHASE_BITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (req_start),
    .busy               (dut_busy),
    .phase_i            (req_phase),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .done_o             (res_done),
    .weight_far_left_o  (res_far_left),
    .weight_near_left_o (res_near_left),
    .weight_near_right_o(res_near_right),
    .weight_far_right_o (res_far_right)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Weight predictor
  // ---------------------------------------------------------------------------------------

  // Division that rounds towards minus infinity; the divisor is always positive here.
  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  // Each weight is an integer part plus a numerator over S^3, where S = 2^PHASE_BITS. Adding
  // one half and taking the floor gives floor((2N + S^3) / (2 S^3)). Everything stays exact
  // in 64 bits over the whole sharpness range.
  function automatic tap_weights_t cubic_tap_weights(input logic [PHASE_W-1:0] phase,
                                                     input logic signed [A_W-1:0] coef);
    longint       s, s2, s3, dd, d2, d3, a, shortfall;
    longint       w[4];
    tap_weights_t r;
    s  = longint'(1) << PHASE_BITS;
    s2 = s * s;
    s3 = s2 * s;
    // Only the low PHASE_BITS bits of the phase take part.
    dd = longint'(phase) & (s - 1);
    d2 = dd * dd;
    d3 = d2 * dd;
    a  = longint'(coef);
    w[0] = floor_div(2 * (a * (dd * s2 - 2 * d2 * s + d3)) + s3, 2 * s3);
    w[1] = 16384 + floor_div(2 * (-(a + 49152) * d2 * s + (a + 32768) * d3) + s3, 2 * s3);
    w[2] = floor_div(2 * (-a * dd * s2 + (2 * a + 49152) * d2 * s - (a + 32768) * d3) + s3,
                     2 * s3);
    w[3] = floor_div(2 * (a * d2 * s - a * d3) + s3, 2 * s3);
    // SystemVerilog division truncates towards zero, which is what the normalisation wants.
    shortfall    = (16384 - w[0] - w[1] - w[2] - w[3]) / 4;
    r.far_left   = OUT_W'(w[0] + shortfall);
    r.near_left  = OUT_W'(w[1] + shortfall);
    r.near_right = OUT_W'(w[2] + shortfall);
    r.far_right  = OUT_W'(w[3] + shortfall);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  function automatic void check_weight(input string name, input logic signed [OUT_W-1:0] want,
                                       input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endfunction

  // A result is on the ports for exactly one cycle and is taken at the edge that ends it.
  // It is compared with the oldest request still waiting for its answer.
  always @(posedge clk_i) begin : result_monitor
    tap_weights_t want;
    if (rst_ni && res_done === 1'b1) begin
      if (pending_weights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with no request waiting for it", $realtime);
        end
      end else begin
        want = pending_weights.pop_front();
        check_weight("weight_far_left", want.far_left, res_far_left);
        check_weight("weight_near_left", want.near_left, res_near_left);
        check_weight("weight_near_right", want.near_right, res_near_right);
        check_weight("weight_far_right", want.far_right, res_far_right);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // All tasks below are entered in the time step of a rising edge. send_phase leaves start
  // high, so back-to-back requests keep it high without a dip; only pause_requests and
  // wait_for_results lower it.
  task automatic send_phase(input logic [PHASE_W-1:0] phase);
    req_start <= 1'b1;
    req_phase <= phase;
    do begin
      @(posedge clk_i);
    end while (dut_busy !== 1'b0);
    // The request is taken with the sharpness in force at this edge.
    pending_weights.push_back(cubic_tap_weights(phase, sharpness_q14));
  endtask

  task automatic pause_requests(input int unsigned cycles);
    req_start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds requests back until every expected result has come. Since each request yields
  // exactly one result, the unit is idle once the queue is empty.
  task automatic wait_for_results();
    req_start <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk_i);
  endtask

  // The register is only written while the unit is idle.
  task automatic write_sharpness(input logic signed [A_W-1:0] coef);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= coef;
    do begin
      @(posedge clk_i);
    end while (cfg_ready !== 1'b1);
    sharpness_q14 = coef;
    cfg_valid <= 1'b0;
  endtask

  // Phase extremes and alternating bit patterns under the sharpness left by reset.
  task automatic test_reset_sharpness();
    logic [PHASE_W-1:0] phases[8] = '{8'h00, 8'h01, 8'h80, 8'hff, 8'h55, 8'haa, 8'h7f, 8'h40};
    foreach (phases[i]) begin
      send_phase(phases[i]);
    end
  endtask

  // The most negative, the most positive and a zero sharpness, each with the phase extremes
  // and the half-pixel point.
  task automatic test_sharpness_extremes();
    logic signed [A_W-1:0] coefs[3]  = '{-16'sd32768, 16'sd32767, 16'sd0};
    logic [PHASE_W-1:0]    phases[4] = '{8'h00, 8'h01, 8'h80, 8'hff};
    foreach (coefs[c]) begin
      write_sharpness(coefs[c]);
      foreach (phases[i]) begin
        send_phase(phases[i]);
      end
    end
  endtask

  // Random phases under one sharpness. With gaps allowed, the sender goes quiet in bursts,
  // in some stretches often and in others not at all, so that pauses land on every stage of
  // the pipeline.
  task automatic test_random_phases(input logic signed [A_W-1:0] coef, input int n_requests,
                                    input bit allow_gaps);
    bit                 gaps_now;
    logic [PHASE_W-1:0] phase;
    write_sharpness(coef);
    gaps_now = allow_gaps;
    for (int i = 0; i < n_requests; i++) begin
      if (allow_gaps && i % 25 == 0) begin
        gaps_now = $urandom_range(0, 2) != 0;
      end
      // Now and then an extreme phase, otherwise any value.
      case ($urandom_range(0, 9))
        0:       phase = '0;
        1:       phase = '1;
        default: phase = PHASE_W'($urandom_range(0, (1 << PHASE_W) - 1));
      endcase
      send_phase(phase);
      if (gaps_now && $urandom_range(0, 5) == 0) begin
        pause_requests($urandom_range(1, 18));
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sharpness();
    test_sharpness_extremes();
    test_random_phases(-16'sd8192, 100, 1'b1);
    test_random_phases(A_W'($urandom_range(0, 65535)), 100, 1'b1);
    test_random_phases(16'sd32767, 100, 1'b1);
    test_random_phases(A_W'($urandom_range(0, 65535)), 100, 1'b1);
    test_random_phases(-16'sd32768, 100, 1'b1);
    // The last part runs back to back with no pauses at all.
    test_random_phases(A_W'($urandom_range(0, 65535)), 100, 1'b0);

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_weights.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run takes well under a millisecond of simulated time.
  initial begin : watchdog
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bwg_pkg.sv
rtl/core/bwg_poly.sv
rtl/core/bicubic_weight_generator_unit.sv
bench/tb.sv
